FILE: rtl/pstl_pkg.sv
`timescale 1ns / 1ps
// pstl_pkg: shared types and constants of the punctuation/string/identifier lexer.
// No dependencies.
package pstl_pkg;

   localparam int TOKEN_LEN_BITS  = 16;
   localparam int TOKEN_POS_BITS  = 16;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS   = FIFO_PTR_BITS + 1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ID   = 2'd2
   } scan_mode_type;

   localparam logic [3:0] KIND_EOF      = 4'd0;
   localparam logic [3:0] KIND_UNCLOSED = 4'd1;
   localparam logic [3:0] KIND_UNKNOWN  = 4'd2;
   localparam logic [3:0] KIND_STRING   = 4'd3;
   localparam logic [3:0] KIND_IDENT    = 4'd4;
   localparam logic [3:0] KIND_LBRACE   = 4'd5;
   localparam logic [3:0] KIND_RBRACE   = 4'd6;
   localparam logic [3:0] KIND_LBRACKET = 4'd7;
   localparam logic [3:0] KIND_RBRACKET = 4'd8;
   localparam logic [3:0] KIND_LPAREN   = 4'd9;
   localparam logic [3:0] KIND_RPAREN   = 4'd10;
   localparam logic [3:0] KIND_COLON    = 4'd11;
   localparam logic [3:0] KIND_SEMI     = 4'd12;
   localparam logic [3:0] KIND_DOT      = 4'd13;
   localparam logic [3:0] KIND_COMMA    = 4'd14;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_USCORE   = 8'h5F;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;

   typedef struct packed {
      logic [3:0]                kind;
      logic [TOKEN_POS_BITS-1:0] start;
      logic [TOKEN_LEN_BITS-1:0] length;
      logic [7:0]                bad_char;
      logic                      last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
             (b == CH_USCORE);
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39));
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] b);
      logic [3:0] k;
      case (b)
         CH_LBRACE:   k = KIND_LBRACE;
         CH_RBRACE:   k = KIND_RBRACE;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         CH_LPAREN:   k = KIND_LPAREN;
         CH_RPAREN:   k = KIND_RPAREN;
         CH_COLON:    k = KIND_COLON;
         CH_SEMI:     k = KIND_SEMI;
         CH_DOT:      k = KIND_DOT;
         CH_COMMA:    k = KIND_COMMA;
         default:     k = KIND_EOF;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/pstl_core.sv
`timescale 1ns / 1ps
// pstl_core: request register, scan state and one-byte token step.
// Depends on pstl_pkg.
module pstl_core #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [7:0]        req_byte,
   input  logic              room,
   output pstl_pkg::push_type push
);
   import pstl_pkg::*;

   logic                     hold_ff, hold_in;
   logic                     cmd_ff;
   logic [7:0]               byte_ff;
   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [TOKEN_LEN_BITS-1:0] plen_ff, plen_in;

   logic                     step;
   logic                     idle_has;
   token_type                idle_tok;
   scan_mode_type            idle_mode;
   logic [TOKEN_LEN_BITS-1:0] idle_len;
   logic [TOKEN_LEN_BITS-1:0] plen_inc;
   logic [POSITION_BITS-1:0] pos_inc;
   token_type                t0, t1;
   logic [1:0]               cnt;

   assign step      = hold_ff && room;
   assign req_ready = !hold_ff || room;
   assign hold_in   = req_valid ? 1'b1 : (hold_ff && !room);

   assign plen_inc = (plen_ff != '1) ? plen_ff + 1'b1 : plen_ff;
   assign pos_inc  = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;

   // byte handling between tokens
   always_comb begin
      idle_has  = 1'b0;
      idle_mode = MODE_IDLE;
      idle_len  = '0;
      idle_tok  = '0;
      idle_tok.start = TOKEN_POS_BITS'(pos_ff);
      if (is_space(byte_ff)) begin
         idle_has = 1'b0;
      end else if (byte_ff == CH_QUOTE) begin
         idle_mode = MODE_STR;
      end else if (punct_kind(byte_ff) != KIND_EOF) begin
         idle_has      = 1'b1;
         idle_tok.kind = punct_kind(byte_ff);
      end else if (is_letter(byte_ff)) begin
         idle_mode = MODE_ID;
         idle_len  = TOKEN_LEN_BITS'(1);
      end else begin
         idle_has          = 1'b1;
         idle_tok.kind     = KIND_UNKNOWN;
         idle_tok.bad_char = byte_ff;
      end
   end

   always_comb begin
      t0        = '0;
      t1        = '0;
      cnt       = 2'd0;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      if (step) begin
         if (cmd_ff == CMD_END) begin
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            pstart_in = '0;
            plen_in   = '0;
            t1.kind   = KIND_EOF;
            t1.start  = TOKEN_POS_BITS'(pos_ff);
            case (mode_ff)
               MODE_ID: begin
                  t0.kind   = KIND_IDENT;
                  t0.start  = TOKEN_POS_BITS'(pstart_ff);
                  t0.length = plen_ff;
                  cnt       = 2'd2;
               end
               MODE_STR: begin
                  t0.kind  = KIND_UNCLOSED;
                  t0.start = TOKEN_POS_BITS'(pstart_ff);
                  cnt      = 2'd2;
               end
               default: begin
                  t0  = t1;
                  cnt = 2'd1;
               end
            endcase
         end else begin
            pos_in = pos_inc;
            case (mode_ff)
               MODE_STR: begin
                  if (byte_ff == CH_QUOTE) begin
                     t0.kind   = KIND_STRING;
                     t0.start  = TOKEN_POS_BITS'(pstart_ff);
                     t0.length = plen_ff;
                     cnt       = 2'd1;
                     mode_in   = MODE_IDLE;
                  end else begin
                     plen_in = plen_inc;
                  end
               end
               MODE_ID: begin
                  if (is_word(byte_ff)) begin
                     plen_in = plen_inc;
                  end else begin
                     t0.kind   = KIND_IDENT;
                     t0.start  = TOKEN_POS_BITS'(pstart_ff);
                     t0.length = plen_ff;
                     t1        = idle_tok;
                     cnt       = idle_has ? 2'd2 : 2'd1;
                     mode_in   = idle_mode;
                     if (idle_mode != MODE_IDLE) begin
                        pstart_in = pos_ff;
                        plen_in   = idle_len;
                     end
                  end
               end
               default: begin
                  t0      = idle_tok;
                  cnt     = idle_has ? 2'd1 : 2'd0;
                  mode_in = idle_mode;
                  if (idle_mode != MODE_IDLE) begin
                     pstart_in = pos_ff;
                     plen_in   = idle_len;
                  end
               end
            endcase
         end
      end
      t0.last = (cnt == 2'd1);
      t1.last = (cnt == 2'd2);
   end

   assign push.count = cnt;
   assign push.tok0  = t0;
   assign push.tok1  = t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else begin
         hold_ff   <= hold_in;
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_byte;
      end
   end

endmodule

FILE: rtl/pstl_fifo.sv
`timescale 1ns / 1ps
// pstl_fifo: small token queue taking up to two tokens per cycle.
// Depends on pstl_pkg.
module pstl_fifo (
   input  logic                clock,
   input  logic                reset,
   input  pstl_pkg::push_type  push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output pstl_pkg::token_type out_tok
);
   import pstl_pkg::*;

   localparam logic [FIFO_CNT_BITS-1:0] ROOM_LIMIT = FIFO_CNT_BITS'(FIFO_DEPTH - 2);

   token_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ff, wr_in;
   logic [FIFO_PTR_BITS-1:0]  rd_ff, rd_in;
   logic [FIFO_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [FIFO_PTR_BITS-1:0]  wr_next;
   logic                      pop;

   assign room      = (cnt_ff <= ROOM_LIMIT);
   assign out_valid = (cnt_ff != '0);
   assign out_tok   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ff + 1'b1;

   assign wr_in  = wr_ff + FIFO_PTR_BITS'(push.count);
   assign rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

endmodule

FILE: rtl/punctuation_string_ident_lexer.sv
`timescale 1ns / 1ps
// Lexer top: one byte request per cycle in while the token queue has room, token results out.
// A request is registered in the core, and its tokens are then written into the token queue.
// One request is taken per cycle while results drain; the tokens of a request that gives two
// leave one at a time through the single output port of the token queue.
// Reset (synchronous, active high) clears scan state, position and queue.
module punctuation_string_ident_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length, [39:32] bad_char
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);
   import pstl_pkg::*;

   push_type  push;
   logic      room;
   token_type out_tok;

   pstl_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser[0]),
      .req_byte  (req_tdata),
      .room      (room),
      .push      (push)
   );

   pstl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok)
   );

   assign rsp_tdata = {out_tok.bad_char, out_tok.length, out_tok.start};
   assign rsp_tuser = out_tok.kind;
   assign rsp_tlast = out_tok.last;

endmodule

FILE: test/punctuation_string_ident_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for punctuation_string_ident_lexer: directed table and random texts;
// typed rows carry their expected token, all else is checked against a behavioral token predictor.
// Depends on pstl_pkg and the lexer RTL.
module punctuation_string_ident_lexer_tb;
   import pstl_pkg::*;

   typedef struct {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  bad;
      logic        last;
   } lex_tok_type;

   typedef struct {
      logic        cmd;
      logic [7:0]  ch;
      bit          typed;
      logic [3:0]  kind;
      logic [15:0] start;
      logic [7:0]  bad;
   } dir_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_byte
   logic [0:0]  req_tuser  = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [15:0] token_start, [31:16] token_length, [39:32] bad_char
   logic [3:0]  rsp_tuser;         // [3:0] token_kind
   logic        rsp_tlast;

   punctuation_string_ident_lexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   scan_mode_type lex_mode   = MODE_IDLE;
   logic [15:0]   lex_pos    = '0;
   logic [15:0]   lex_pstart = '0;
   logic [15:0]   lex_plen   = '0;

   lex_tok_type step_toks[$];
   lex_tok_type token_q[$];
   dir_row_type dir_rows[$];

   logic [7:0] punct_chars [10] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
                                    CH_LPAREN, CH_RPAREN, CH_COLON, CH_SEMI, CH_DOT, CH_COMMA};
   logic [7:0] blank_chars [4]  = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

   bit idle_en   = 1'b1;
   bit hold_req  = 1'b0;
   int hold_left = 0;
   int busy_left = 0;
   int fail_count = 0;
   int req_count  = 0;
   int tok_count  = 0;
   int text_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bit is_blank(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   function automatic bit is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_USCORE;
   endfunction

   function automatic bit is_alnum(input logic [7:0] b);
      return is_alpha(b) || (b >= "0" && b <= "9");
   endfunction

   function automatic logic [3:0] punct_code(input logic [7:0] b);
      for (int i = 0; i < 10; i++)
         if (punct_chars[i] == b) return KIND_LBRACE + 4'(i);
      return KIND_EOF;
   endfunction

   function automatic void emit_tok(input logic [3:0] kind, input logic [15:0] start,
                                    input logic [15:0] length, input logic [7:0] bad);
      lex_tok_type t;
      t = '{kind, start, length, bad, 1'b0};
      step_toks.push_back(t);
   endfunction

   function automatic void lex_idle(input logic [7:0] ch, input logic [15:0] at);
      logic [3:0] k;
      k = punct_code(ch);
      if (is_blank(ch)) begin
      end else if (ch == CH_QUOTE) begin
         lex_mode = MODE_STR;
         lex_pstart = at;
         lex_plen = '0;
      end else if (k != KIND_EOF) begin
         emit_tok(k, at, '0, '0);
      end else if (is_alpha(ch)) begin
         lex_mode = MODE_ID;
         lex_pstart = at;
         lex_plen = 16'd1;
      end else begin
         emit_tok(KIND_UNKNOWN, at, '0, ch);
      end
   endfunction

   function automatic void lex_step(input logic cmd, input logic [7:0] ch);
      logic [15:0] at;
      at = lex_pos;
      step_toks.delete();
      if (cmd == CMD_END) begin
         if (lex_mode == MODE_ID) emit_tok(KIND_IDENT, lex_pstart, lex_plen, '0);
         else if (lex_mode == MODE_STR) emit_tok(KIND_UNCLOSED, lex_pstart, '0, '0);
         emit_tok(KIND_EOF, at, '0, '0);
         lex_mode = MODE_IDLE;
         lex_pos = '0;
         lex_pstart = '0;
         lex_plen = '0;
      end else begin
         case (lex_mode)
            MODE_STR: begin
               if (ch == CH_QUOTE) begin
                  emit_tok(KIND_STRING, lex_pstart, lex_plen, '0);
                  lex_mode = MODE_IDLE;
               end else if (lex_plen != '1) begin
                  lex_plen++;
               end
            end
            MODE_ID: begin
               if (is_alnum(ch)) begin
                  if (lex_plen != '1) lex_plen++;
               end else begin
                  emit_tok(KIND_IDENT, lex_pstart, lex_plen, '0);
                  lex_mode = MODE_IDLE;
                  lex_idle(ch, at);
               end
            end
            default: begin
               lex_mode = MODE_IDLE;
               lex_idle(ch, at);
            end
         endcase
         if (lex_pos != '1) lex_pos++;
      end
      if (step_toks.size() > 0) step_toks[$].last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_en) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_req(input logic cmd, input logic [7:0] ch, input bit typed,
                           input logic [3:0] kind, input logic [15:0] start,
                           input logic [7:0] bad);
      int gap;
      lex_tok_type t;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= cmd;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      lex_step(cmd, ch);
      if (typed) begin
         t = '{kind, start, '0, bad, 1'b1};
         token_q.push_back(t);
      end else begin
         foreach (step_toks[i]) token_q.push_back(step_toks[i]);
      end
      req_count++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      send_req(CMD_BYTE, ch, 1'b0, KIND_EOF, '0, '0);
   endtask

   task automatic send_end();
      send_req(CMD_END, 8'($urandom_range(0, 255)), 1'b0, KIND_EOF, '0, '0);
      text_count++;
   endtask

   function automatic logic [7:0] rand_word(input bit first);
      int r;
      r = $urandom_range(0, first ? 2 : 3);
      case (r)
         0: return 8'("a" + $urandom_range(0, 25));
         1: return 8'("A" + $urandom_range(0, 25));
         2: return CH_USCORE;
         default: return 8'("0" + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] rand_unknown();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (is_blank(b) || b == CH_QUOTE || punct_code(b) != KIND_EOF || is_alpha(b));
      return b;
   endfunction

   function automatic logic [7:0] rand_content();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
      return b;
   endfunction

   task automatic add_row(input logic cmd, input logic [7:0] ch, input bit typed,
                          input logic [3:0] kind, input logic [15:0] start,
                          input logic [7:0] bad);
      dir_row_type r;
      r = '{cmd, ch, typed, kind, start, bad};
      dir_rows.push_back(r);
   endtask

   // random text of tokens, blanks and stray bytes, sometimes left open at the end
   task automatic gen_text();
      int ntok;
      int len;
      ntok = $urandom_range(1, 12);
      repeat (ntok) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_byte(punct_chars[$urandom_range(0, 9)]);
            3, 4: begin
               len = $urandom_range(1, 6);
               send_byte(rand_word(1'b1));
               repeat (len - 1) send_byte(rand_word(1'b0));
            end
            5, 6: begin
               len = $urandom_range(0, 6);
               send_byte(CH_QUOTE);
               repeat (len) send_byte(rand_content());
               send_byte(CH_QUOTE);
            end
            7: repeat ($urandom_range(1, 3)) send_byte(blank_chars[$urandom_range(0, 3)]);
            8: send_byte(rand_unknown());
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 1) == 0) send_byte(blank_chars[$urandom_range(0, 3)]);
      end
      case ($urandom_range(0, 3))
         0: send_byte(rand_word(1'b1));
         1: begin
            send_byte(CH_QUOTE);
            send_byte(rand_content());
         end
         default: begin
         end
      endcase
      send_end();
   endtask

   // receiver: random back-pressure plus one long hold on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (busy_left > 0) begin
            busy_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 3) == 0) busy_left = pick_gap();
         end
      end
   end

   // token checker; a token is taken at the edge after this sample
   always @(negedge clock) begin
      lex_tok_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tok_count++;
         if (token_q.size() == 0) begin
            $error("unexpected token: kind %0d start %0d", rsp_tuser, rsp_tdata[15:0]);
            fail_count++;
         end else begin
            e = token_q.pop_front();
            if (rsp_tuser !== e.kind) begin
               $error("token_kind: expected %0d, got %0d", e.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[15:0] !== e.start) begin
               $error("token_start: expected %0d, got %0d", e.start, rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[31:16] !== e.length) begin
               $error("token_length: expected %0d, got %0d", e.length, rsp_tdata[31:16]);
               fail_count++;
            end
            if (rsp_tdata[39:32] !== e.bad) begin
               $error("bad_char: expected 0x%02h, got 0x%02h", e.bad, rsp_tdata[39:32]);
               fail_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_of_run: expected %0b, got %0b", e.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int dir_count;
      bit hold_done;
      hold_done = 1'b0;

      // directed table: typed rows carry their single expected token
      add_row(CMD_END,  8'h00, 1'b1, KIND_EOF, 16'd0, 8'h00);
      foreach (punct_chars[i])
         add_row(CMD_BYTE, punct_chars[i], 1'b1, KIND_LBRACE + 4'(i), 16'(i), 8'h00);
      foreach (blank_chars[i])
         add_row(CMD_BYTE, blank_chars[i], 1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b1, KIND_UNKNOWN, 16'd14, 8'hFF);
      add_row(CMD_BYTE, 8'h00, 1'b1, KIND_UNKNOWN, 16'd15, 8'h00);
      add_row(CMD_BYTE, "a",       1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, "Z",       1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, "9",       1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, CH_USCORE, 1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, CH_RPAREN, 1'b0, KIND_EOF, '0, '0);   // ident closed by punct
      add_row(CMD_BYTE, CH_QUOTE,  1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, "q",       1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, CH_QUOTE,  1'b0, KIND_EOF, '0, '0);
      add_row(CMD_BYTE, CH_USCORE, 1'b0, KIND_EOF, '0, '0);
      add_row(CMD_END,  8'hA5,     1'b0, KIND_EOF, '0, '0);   // ident flushed at end
      add_row(CMD_BYTE, CH_QUOTE,  1'b0, KIND_EOF, '0, '0);
      add_row(CMD_END,  8'h5A,     1'b0, KIND_EOF, '0, '0);   // unclosed string

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].kind,
                  dir_rows[i].start, dir_rows[i].bad);
      dir_count = req_count;

      while (req_count < dir_count + 700) begin
         idle_en = ($urandom_range(0, 4) != 0);
         if (!hold_done && req_count > dir_count + 350) begin
            hold_done = 1'b1;
            idle_en = 1'b0;
            hold_req = 1'b1;
            repeat (30) send_byte(punct_chars[$urandom_range(0, 9)]);
            send_end();
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
               send_req(($urandom_range(0, 15) == 0) ? CMD_END : CMD_BYTE,
                        8'($urandom_range(0, 255)), 1'b0, KIND_EOF, '0, '0);
            send_end();
         end else begin
            gen_text();
         end
      end

      req_tvalid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Lexed %0d requests over %0d texts and checked %0d tokens,", req_count,
               text_count, tok_count);
      $display("including random gaps, raw byte runs and a long output hold.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
